// File: hdl/ptd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_pkg: shared types for the trial-division primality tester
// Controller state encoding and fixed constants.
// ----------------------------------------------------------------------------
package ptd_pkg;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } ptd_state_t;

  // first odd trial divisor and divisor step
  localparam int unsigned FIRST_DIVISOR = 3;
  localparam int unsigned DIVISOR_STEP  = 2;

  // result word is one byte
  localparam int unsigned OUT_WIDTH = 8;

endpackage

// File: hdl/ptd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_div: bit-serial restoring divider
// One quotient bit per cycle; quotient and remainder valid when done pulses.
// ----------------------------------------------------------------------------
module ptd_div #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    part;
  logic [W:0]    diff;
  logic          ge;

  assign part = {rem_r, quo_r[W-1]};
  assign ge   = part >= {1'b0, dvs_r};
  assign diff = part - {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(W - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      quo_nxt = {quo_r[W-2:0], ge};
      rem_nxt = ge ? diff[W-1:0] : part[W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: hdl/prime_test_trial_division.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_test_trial_division: primality test by trial division
// Streams in one unsigned value per word, returns one is_prime word.
// ----------------------------------------------------------------------------
// Values below 2 and even values above 2 are answered without a trial division;
// 2 and 3 are prime at once. Odd values go through trial divisors 3, 5, 7 and
// onward until the divisor exceeds the quotient (prime) or leaves no remainder
// (not prime). Each trial is one pass of a bit-serial divider. One value is
// worked on at a time; the next value is taken while the previous result waits
// on out_.
// ----------------------------------------------------------------------------
module prime_test_trial_division #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [8*((VALUE_WIDTH+7)/8)-1:0]      in_tdata,   // [VALUE_WIDTH-1:0] value
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [ptd_pkg::OUT_WIDTH-1:0]         out_tdata   // [0] is_prime
);
  import ptd_pkg::*;

  localparam int unsigned W = VALUE_WIDTH;

  ptd_state_t   state_r, state_nxt;
  logic [W-1:0] val_r, val_nxt;
  logic [W-1:0] dvs_r, dvs_nxt;
  logic         start_r, start_nxt;
  logic         res_r, res_nxt;
  logic         out_tvalid_r, out_tvalid_nxt;
  logic         out_bit_r, out_bit_nxt;
  logic [W-1:0] in_value;
  logic         in_acc;
  logic         div_done;
  logic [W-1:0] div_quo;
  logic [W-1:0] div_rem;
  logic         out_free;

  ptd_div #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .dividend  (val_r),
    .divisor   (dvs_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign in_value = in_tdata[W-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    val_nxt        = val_r;
    dvs_nxt        = dvs_r;
    start_nxt      = 1'b0;
    res_nxt        = res_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_bit_nxt    = out_bit_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          val_nxt = in_value;
          if (in_value < W'(2)) begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else if (in_value < W'(4)) begin
            res_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else if (!in_value[0]) begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            dvs_nxt   = W'(FIRST_DIVISOR);
            start_nxt = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (dvs_r > div_quo) begin
            res_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else if (div_rem == '0) begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            dvs_nxt   = dvs_r + W'(DIVISOR_STEP);
            start_nxt = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_bit_nxt    = res_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      start_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      start_r      <= start_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    val_r     <= val_nxt;
    dvs_r     <= dvs_nxt;
    res_r     <= res_nxt;
    out_bit_r <= out_bit_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_WIDTH-1){1'b0}}, out_bit_r};

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside a trial");

  a_start_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> state_r == S_DIV)
    else $error("divider started outside a trial");

  a_divisor_odd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> dvs_r[0])
    else $error("even trial divisor");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tready |=> out_tvalid_r && $stable(out_bit_r))
    else $error("pending result dropped or changed");

endmodule
